@@ hdl/b2d128_pkg.sv @@
// Shared types and constants for the 128-bit binary to decimal ASCII converter.
// Used by binary_to_decimal_128; depends on nothing else.

package b2d128_pkg;

  // Width of each half of the incoming binary value.
  localparam int unsigned HALF_WIDTH = 64;

  // ASCII code of the character '0', in the width of the digit field.
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // One input request: the unsigned value as two 64-bit halves.
  typedef struct packed {
    logic [HALF_WIDTH-1:0] value_high;
    logic [HALF_WIDTH-1:0] value_low;
  } in_req_t;

  // One output request: a single decimal digit character.
  typedef struct packed {
    logic [5:0] digit_char;
    logic       last_digit;
  } out_req_t;

endpackage

@@ hdl/binary_to_decimal_128.sv @@
// Binary to decimal ASCII converter. The value is converted bit-serially; leading zero
// digits are then dropped one per cycle and the digits are sent one per unstalled cycle.
// A new request is taken only after the last digit of the previous one has been loaded
// into the output register, so requests do not overlap.
// Reset (rst_n low, synchronous) returns to idle with no output request pending.

module binary_to_decimal_128 #(
  parameter int unsigned VALUE_WIDTH = 128,
  parameter int unsigned MAX_DIGITS  = 39
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  b2d128_pkg::in_req_t   in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output b2d128_pkg::out_req_t  out_req
);

  // The BCD register holds MAX_DIGITS packed decimal digits, most significant
  // digit at the top. The bit counter walks over every bit of the value.
  localparam int unsigned BCD_W = MAX_DIGITS * 4;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
  localparam int unsigned DIG_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  ovf_r, ovf_nxt;
  logic [CNT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [DIG_W-1:0]      dig_left_r, dig_left_nxt;
  logic                  out_valid_r, out_valid_nxt;
  b2d128_pkg::out_req_t  out_req_r, out_req_nxt;

  logic [2*b2d128_pkg::HALF_WIDTH-1:0] in_word;
  logic [3:0]            top_digit;
  logic                  out_free;
  logic                  emit_load;

  // The full 128-bit input; bits above VALUE_WIDTH are simply not taken.
  assign in_word   = {in_req.value_high, in_req.value_low};
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // The output register can take a new digit when it is empty or being read.
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_load = (state_r == ST_EMIT) && out_free;

  // Shared double-dabble adjust unit: every digit of 5 or more gets 3 added,
  // so that the following left shift carries correctly into the next digit.
  always_comb begin
    logic [3:0] dig;
    dig     = '0;
    bcd_adj = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig = bcd_r[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // Sequencer. A new request is taken only in idle. The conversion shifts one
  // value bit per cycle into the BCD register; anything shifted out of the top
  // digit marks an overflow, after which all MAX_DIGITS digits (the least
  // significant ones) are sent, leading zeros included. Without overflow,
  // leading zero digits are dropped one per cycle, keeping at least one digit.
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    bcd_nxt       = bcd_r;
    ovf_nxt       = ovf_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_left_nxt  = dig_left_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_req_nxt   = out_req_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt      = in_word[VALUE_WIDTH-1:0];
          bcd_nxt      = '0;
          ovf_nxt      = 1'b0;
          bit_cnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
          dig_left_nxt = DIG_W'(MAX_DIGITS);
          state_nxt    = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], val_r[VALUE_WIDTH-1]};
        val_nxt     = {val_r[VALUE_WIDTH-2:0], 1'b0};
        ovf_nxt     = ovf_r || bcd_adj[BCD_W-1];
        bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (ovf_r || (dig_left_r == DIG_W'(1)) || (top_digit != 4'd0)) begin
          state_nxt = ST_EMIT;
        end else begin
          bcd_nxt      = {bcd_r[BCD_W-5:0], 4'd0};
          dig_left_nxt = dig_left_r - DIG_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_req_nxt.digit_char = b2d128_pkg::ASCII_ZERO + {2'b00, top_digit};
          out_req_nxt.last_digit = (dig_left_r == DIG_W'(1));
          bcd_nxt                = {bcd_r[BCD_W-5:0], 4'd0};
          dig_left_nxt           = dig_left_r - DIG_W'(1);
          if (dig_left_r == DIG_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state is reset; the datapath registers are only meaningful once a
  // request has been taken, so they carry no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    bcd_r      <= bcd_nxt;
    ovf_r      <= ovf_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_left_r <= dig_left_nxt;
    out_req_r  <= out_req_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // The remaining digit count never exceeds the digit capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (dig_left_r <= DIG_W'(MAX_DIGITS)))
    else $error("digit count exceeds capacity");

  // The conversion ends in the leading-zero stage after the last value bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONVERT && bit_cnt_r == '0) |=> (state_r == ST_SKIP))
    else $error("conversion did not end after the last bit");

  // Loading the final digit returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && dig_left_r == DIG_W'(1)) |=> (state_r == ST_IDLE && out_req_r.last_digit))
    else $error("final digit did not end the request");

  // A new output request only appears while digits are being sent.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("output request outside the send stage");

endmodule

@@ bench/binary_to_decimal_128_tb.sv @@
// Self-checking testbench for binary_to_decimal_128, the 128-bit to decimal ASCII converter.
// Depends on b2d128_pkg for the request types and on the converter RTL; nothing else.

module binary_to_decimal_128_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_WIDTH    = 128;
  localparam int unsigned MAX_DIGITS     = 39;
  // No accepted request in either direction for this many cycles means the block hung.
  // A slow correct run sees a full conversion plus the receiver hold-off, under this limit.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_OFF_LEN   = 600;
  localparam int unsigned TAIL_CYCLES    = 250;
  localparam int unsigned PHASE_ITEMS    = 110;
  localparam int unsigned BURST_ITEMS    = 12;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  b2d128_pkg::in_req_t  in_req    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  b2d128_pkg::out_req_t out_req;

  // Values waiting to be offered, and the digit characters the block still owes us.
  b2d128_pkg::in_req_t  pending_values[$];
  b2d128_pkg::out_req_t expected_digits[$];

  bit [127:0]  power_of_ten[MAX_DIGITS];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_left  = 0;
  int unsigned values_taken   = 0;
  int unsigned directed_count = 0;
  int unsigned digits_checked = 0;
  int unsigned longest_number = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  binary_to_decimal_128 #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Converts one accepted value into the digit characters the block must emit.
  // Digits are peeled off least significant first by dividing by ten, then queued
  // most significant first; only the MAX_DIGITS lowest digits would survive.
  function automatic void queue_decimal_digits(input b2d128_pkg::in_req_t req);
    bit [127:0]           rest;
    bit [3:0]             low_first[$];
    b2d128_pkg::out_req_t digit;
    rest = {req.value_high, req.value_low} & ((128'd1 << VALUE_WIDTH) - 128'd1);
    do begin
      if (low_first.size() < MAX_DIGITS) begin
        low_first.push_back(4'(rest % 128'd10));
      end
      rest = rest / 128'd10;
    end while (rest != 0);
    if (low_first.size() > longest_number) begin
      longest_number = low_first.size();
    end
    for (int k = low_first.size() - 1; k >= 0; k--) begin
      digit.digit_char = b2d128_pkg::ASCII_ZERO + 6'(low_first[k]);
      digit.last_digit = (k == 0);
      expected_digits.push_back(digit);
    end
  endfunction

  // Driver. A request stays on the bus unchanged until the block takes it; only
  // then does the next one go out, possibly after random idle cycles. The
  // accepted value is predicted on the same edge, well before any digit can leave.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        queue_decimal_digits(in_req);
        values_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure. A requested hold-off is counted down here, one cycle
  // at a time, and overrides the random stalling while it lasts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_left != 0) begin
      out_stall     <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor. Every digit the block hands over is matched against the oldest
  // outstanding prediction, field by field.
  always @(posedge clk) begin
    b2d128_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected digit: digit_char %0d last_digit %0d",
               out_req.digit_char, out_req.last_digit);
        mismatches++;
      end else begin
        want = expected_digits.pop_front();
        if (out_req.digit_char !== want.digit_char) begin
          $error("digit_char: expected %0d, got %0d", want.digit_char, out_req.digit_char);
          mismatches++;
        end
        if (out_req.last_digit !== want.last_digit) begin
          $error("last_digit: expected %0d, got %0d", want.last_digit, out_req.last_digit);
          mismatches++;
        end
        digits_checked++;
      end
    end
  end

  // Watchdog. Any accepted request on either side proves progress.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_value(input bit [127:0] value);
    pending_values.push_back(b2d128_pkg::in_req_t'(value));
  endtask

  // Stops feeding until the driver is empty and every owed digit has arrived.
  task automatic wait_for_drain();
    do begin
      @(negedge clk);
    end while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0);
  endtask

  // Queues a batch of random values under one idling pattern, then drains.
  // The mix favors shapes that stress the digit count and carries: full-width
  // noise, values trimmed to a random bit length, neighbors of powers of ten,
  // small numbers with few digits, and single-bit or all-ones patterns.
  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input int unsigned count);
    bit [127:0]  value;
    int unsigned width;
    int unsigned k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      case ($urandom_range(6)) inside
        0, 1: value = {$urandom, $urandom, $urandom, $urandom};
        2: begin
          width = $urandom_range(1, 128);
          value = {$urandom, $urandom, $urandom, $urandom} & ((128'd1 << width) - 128'd1);
        end
        3, 4: begin
          k     = $urandom_range(MAX_DIGITS - 1);
          value = power_of_ten[k];
          case ($urandom_range(2))
            0: value = value - 128'd1;
            1: value = value + 128'd1;
            default: ;
          endcase
        end
        5: value = 128'($urandom_range(999));
        default: begin
          width = $urandom_range(1, 128);
          value = $urandom_range(1) ? (128'd1 << (width - 1)) : ((128'd1 << width) - 128'd1);
        end
      endcase
      add_value(value);
    end
    wait_for_drain();
  endtask

  initial begin
    power_of_ten[0] = 128'd1;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      power_of_ten[i] = power_of_ten[i - 1] * 128'd10;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed values: zero, digit-count boundaries, the 32- and 64-bit seams,
    // the largest 39-digit input and patterns that toggle every bit of both halves.
    add_value(128'd0);
    add_value(128'd1);
    add_value(128'd9);
    add_value(128'd10);
    add_value(128'd99);
    add_value(128'd100);
    add_value(128'hFFFF_FFFF);
    add_value(128'h1_0000_0000);
    add_value({64'd0, {64{1'b1}}});
    add_value({64'd1, 64'd0});
    add_value({64'd1, 64'd1});
    add_value(power_of_ten[19] - 128'd1);
    add_value(power_of_ten[19]);
    add_value(power_of_ten[20]);
    add_value(power_of_ten[38] - 128'd1);
    add_value(power_of_ten[38]);
    add_value(128'd1 << 127);
    add_value({128{1'b1}});
    add_value({{64{1'b1}}, 64'd0});
    add_value({64{2'b01}});
    add_value({64{2'b10}});
    directed_count = pending_values.size();
    wait_for_drain();

    // Random phases with different idling on either side.
    run_random_phase(0, 0, PHASE_ITEMS);
    run_random_phase(54, 0, PHASE_ITEMS);
    run_random_phase(0, 54, PHASE_ITEMS);
    run_random_phase(14, 14, PHASE_ITEMS);

    // Long receiver hold-off while the sender keeps offering wide values, so the
    // converter fills up and has to stall its input; then a full drain.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = HOLD_OFF_LEN;
    repeat (BURST_ITEMS) begin
      add_value({$urandom, $urandom, $urandom, $urandom});
    end
    wait_for_drain();

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Converted %0d values (%0d directed) into %0d checked digit characters;",
             values_taken, directed_count, digits_checked);
    $display("longest number %0d digits, idle and stall phases plus a %0d-cycle hold-off.",
             longest_number, HOLD_OFF_LEN);
    if (mismatches == 0 && expected_digits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/b2d128_pkg.sv
hdl/binary_to_decimal_128.sv
bench/binary_to_decimal_128_tb.sv
